### rtl/mmvn_pkg.sv
// Shared types and constants for the min-max volume normaliser.
// Used by mmvn_scaler and min_max_volume_normaliser_unit; depends on nothing.
package mmvn_pkg;

   localparam int SampleWidth = 32;
   localparam int ScaleWidth  = 16;

   // Shift-add multiply runs one full-scale bit per step; the divide needs one extra
   // quotient bit so that the result can be rounded to nearest.
   localparam int MulSteps   = ScaleWidth;
   localparam int DivSteps   = ScaleWidth + 1;
   localparam int CountWidth = $clog2(DivSteps);

   localparam logic [ScaleWidth-1:0] FullScaleReset = ScaleWidth'(4000);

   typedef enum logic [1:0] {
      REQ_RESTART = 2'd0,
      REQ_SCAN    = 2'd1,
      REQ_SCALE   = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      SCL_IDLE,
      SCL_MUL,
      SCL_DIV,
      SCL_ROUND,
      SCL_HOLD
   } scl_state_type;

   typedef struct packed {
      logic                   start;
      logic                   bypass;
      logic                   bypass_degenerate;
      logic [ScaleWidth-1:0]  bypass_scaled;
      logic [SampleWidth-1:0] diff;
      logic [SampleWidth-1:0] den;
      logic [ScaleWidth-1:0]  full_scale;
   } scl_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } scl_status_type;

endpackage

### rtl/mmvn_scaler.sv
// Bit-serial scaler: shift-add multiply, restoring divide and round to nearest.
// Depends on mmvn_pkg.
module mmvn_scaler
   import mmvn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  scl_cmd_type           cmd,
   input  logic                  take,
   output scl_status_type        status,
   output logic [ScaleWidth-1:0] res_scaled,
   output logic                  res_degenerate
);

   scl_state_type state_ff, state_in;

   logic [CountWidth-1:0]  count_ff, count_in;
   logic [SampleWidth-1:0] mcand_ff, mcand_in;
   logic [SampleWidth-1:0] den_ff, den_in;
   logic [SampleWidth-1:0] hi_ff, hi_in;
   logic [ScaleWidth-1:0]  lo_ff, lo_in;
   logic [ScaleWidth:0]    quot_ff, quot_in;
   logic [ScaleWidth-1:0]  scaled_ff, scaled_in;
   logic                   degen_ff, degen_in;

   logic [SampleWidth:0]   mul_sum;
   logic [SampleWidth:0]   trial;
   logic [SampleWidth:0]   trial_diff;
   logic                   trial_ge;
   logic [ScaleWidth+1:0]  rounded;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SCL_IDLE: begin
            if (cmd.start) begin
               state_in = cmd.bypass ? SCL_HOLD : SCL_MUL;
            end
         end
         SCL_MUL: begin
            if (count_ff == CountWidth'(MulSteps - 1)) begin
               state_in = SCL_DIV;
            end
         end
         SCL_DIV: begin
            if (count_ff == CountWidth'(DivSteps - 1)) begin
               state_in = SCL_ROUND;
            end
         end
         SCL_ROUND: begin
            state_in = SCL_HOLD;
         end
         SCL_HOLD: begin
            if (take) begin
               state_in = SCL_IDLE;
            end
         end
         default: begin
            state_in = SCL_IDLE;
         end
      endcase
   end

   // One multiplier bit per step: add the multiplicand on a set bit, then shift right.
   assign mul_sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);

   // One quotient bit per step: bring down the next dividend bit and trial-subtract.
   assign trial      = {hi_ff, quot_ff[ScaleWidth]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign trial_ge   = (trial >= {1'b0, den_ff});

   // quot_ff holds floor(2*num/den); adding one and halving rounds half up.
   assign rounded = ({1'b0, quot_ff} + (ScaleWidth+2)'(1)) >> 1;

   always_comb begin
      count_in  = count_ff;
      mcand_in  = mcand_ff;
      den_in    = den_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      quot_in   = quot_ff;
      scaled_in = scaled_ff;
      degen_in  = degen_ff;
      case (state_ff)
         SCL_IDLE: begin
            count_in  = '0;
            mcand_in  = cmd.diff;
            den_in    = cmd.den;
            hi_in     = '0;
            lo_in     = cmd.full_scale;
            scaled_in = cmd.bypass_scaled;
            degen_in  = cmd.bypass_degenerate;
         end
         SCL_MUL: begin
            hi_in = mul_sum[SampleWidth:1];
            lo_in = {mul_sum[0], lo_ff[ScaleWidth-1:1]};
            if (count_ff == CountWidth'(MulSteps - 1)) begin
               count_in = '0;
               // The dividend is twice the product: its low bits enter below the remainder.
               quot_in  = {lo_in, 1'b0};
            end else begin
               count_in = count_ff + CountWidth'(1);
            end
         end
         SCL_DIV: begin
            hi_in    = trial_ge ? trial_diff[SampleWidth-1:0] : trial[SampleWidth-1:0];
            quot_in  = {quot_ff[ScaleWidth-1:0], trial_ge};
            if (count_ff == CountWidth'(DivSteps - 1)) begin
               count_in = '0;
            end else begin
               count_in = count_ff + CountWidth'(1);
            end
         end
         SCL_ROUND: begin
            scaled_in = rounded[ScaleWidth-1:0];
            degen_in  = 1'b0;
         end
         SCL_HOLD: begin
            count_in = '0;
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCL_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      den_ff    <= den_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      quot_ff   <= quot_in;
      scaled_ff <= scaled_in;
      degen_ff  <= degen_in;
   end

   assign status.busy    = (state_ff != SCL_IDLE);
   assign status.done    = (state_ff == SCL_HOLD);
   assign res_scaled     = scaled_ff;
   assign res_degenerate = degen_ff;

   // The partial remainder always stays below the divisor while dividing.
   a_rem_below_den : assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCL_DIV) |-> (hi_ff < den_ff))
      else $error("scaler remainder not below divisor");

   // The step counter never runs past the longer of the two phases.
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CountWidth'(DivSteps - 1)))
      else $error("scaler step counter out of range");

endmodule

### rtl/min_max_volume_normaliser_unit.sv
// Top level of the min-max volume normaliser: statistics, request and response channels.
// Depends on mmvn_pkg and mmvn_scaler.
//
// The host opens a volume with a restart transaction, streams every Q16.16 sample as a
// scan transaction so the block can track the minimum and maximum, and then streams the
// samples again as scale transactions; each scale transaction returns one response with
// round(full_scale * (sample - min) / (max - min)), rounded half up and held to
// 0..full_scale, or 0 with the degenerate flag when max equals min. Restart, scan and
// ignored codes complete in the cycle they are accepted and produce no response. A scale
// transaction whose sample lies inside the open range passes, after its acceptance, through
// a bit-serial shift-add multiply by full_scale, a restoring divide that produces one
// quotient bit a cycle, a rounding step and a hand-off of the result to the output register,
// before the next transaction can be accepted. Samples at or beyond the limits, and
// degenerate ranges, skip the arithmetic and go straight to the hand-off. The multiply-divide
// unit is the only slow element, so one scale transaction is in flight at a time; the
// response register lets the next transaction in while the previous response waits.
// full_scale is to be written only while the block is idle; the block does not enforce this.
module min_max_volume_normaliser_unit
   import mmvn_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic signed [SampleWidth-1:0] req_sample,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ScaleWidth-1:0]         rsp_scaled,
   output logic                          rsp_degenerate,

   input  logic                          csr_wr_en,
   input  logic [ScaleWidth-1:0]         csr_wr_data
);

   logic [ScaleWidth-1:0]         full_scale_ff;
   logic signed [SampleWidth-1:0] min_ff, min_in;
   logic signed [SampleWidth-1:0] max_ff, max_in;
   logic                          seen_any_ff, seen_any_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ScaleWidth-1:0]         rsp_scaled_ff, rsp_scaled_in;
   logic                          rsp_degen_ff, rsp_degen_in;

   logic                          req_fire;
   logic                          range_degenerate;
   logic                          at_or_below_min;
   logic                          at_or_above_max;
   logic                          out_load;

   scl_cmd_type                   scl_cmd;
   scl_status_type                scl_status;
   logic [ScaleWidth-1:0]         scl_scaled;
   logic                          scl_degenerate;

   // Only one scale transaction can be in the scaler at a time; restart, scan and
   // ignored codes complete in the cycle they are accepted.
   assign req_ready = !scl_status.busy;
   assign req_fire  = req_valid && req_ready;

   assign range_degenerate = (max_ff == min_ff);
   assign at_or_below_min  = (req_sample <= min_ff);
   assign at_or_above_max  = (req_sample >= max_ff);

   // Statistics update. A code outside the defined set leaves everything unchanged.
   always_comb begin
      min_in      = min_ff;
      max_in      = max_ff;
      seen_any_in = seen_any_ff;
      if (req_fire) begin
         case (req_type)
            REQ_RESTART: begin
               min_in      = '0;
               max_in      = '0;
               seen_any_in = 1'b0;
            end
            REQ_SCAN: begin
               seen_any_in = 1'b1;
               if (!seen_any_ff) begin
                  min_in = req_sample;
                  max_in = req_sample;
               end else begin
                  if (req_sample > max_ff) begin
                     max_in = req_sample;
                  end
                  if (req_sample < min_ff) begin
                     min_in = req_sample;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // A scale transaction goes to the scaler. When the answer is already known
   // (degenerate range, or the sample sits at or past a limit) the scaler only
   // carries it through its result register.
   always_comb begin
      scl_cmd.start             = req_fire && (req_type == REQ_SCALE);
      scl_cmd.bypass            = range_degenerate || at_or_below_min || at_or_above_max;
      scl_cmd.bypass_degenerate = range_degenerate;
      scl_cmd.bypass_scaled     = (!range_degenerate && !at_or_below_min) ?
                                  full_scale_ff : '0;
      scl_cmd.diff              = req_sample - min_ff;
      scl_cmd.den               = max_ff - min_ff;
      scl_cmd.full_scale        = full_scale_ff;
   end

   mmvn_scaler u_scaler (
      .clock          (clock),
      .reset          (reset),
      .cmd            (scl_cmd),
      .take           (out_load),
      .status         (scl_status),
      .res_scaled     (scl_scaled),
      .res_degenerate (scl_degenerate)
   );

   // Response register: it loads a finished scaler result when it is empty or being emptied this cycle.
   assign out_load = scl_status.done && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_scaled_in = rsp_scaled_ff;
      rsp_degen_in  = rsp_degen_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_scaled_in = scl_scaled;
         rsp_degen_in  = scl_degenerate;
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= FullScaleReset;
         min_ff        <= '0;
         max_ff        <= '0;
         seen_any_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            full_scale_ff <= csr_wr_data;
         end
         min_ff       <= min_in;
         max_ff       <= max_in;
         seen_any_ff  <= seen_any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_scaled_ff <= rsp_scaled_in;
      rsp_degen_ff  <= rsp_degen_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scaled     = rsp_scaled_ff;
   assign rsp_degenerate = rsp_degen_ff;

   // Once a sample has been scanned the tracked range is never inverted.
   a_range_ordered : assert property (@(posedge clock) disable iff (reset)
      seen_any_ff |-> (min_ff <= max_ff))
      else $error("tracked minimum above maximum");

   // With nothing scanned both limits sit at zero.
   a_empty_stats : assert property (@(posedge clock) disable iff (reset)
      !seen_any_ff |-> ((min_ff == '0) && (max_ff == '0)))
      else $error("statistics not cleared");

   // A degenerate response always carries a zero value.
   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_degen_ff) |-> (rsp_scaled_ff == '0))
      else $error("degenerate response with nonzero value");

   // A regular response never exceeds the programmed full scale.
   a_within_scale : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_degen_ff) |-> (rsp_scaled_ff <= full_scale_ff))
      else $error("response above full scale");

endmodule
